>>> sv/nccls_pkg.sv
// nccls_pkg: shared constants, microcode types and the sequencer program
// for the nearest-codeword classifier
// no dependencies
`default_nettype none

package nccls_pkg;

    localparam int NUM_ENTRIES_DEF = 256;
    localparam int VECTOR_LEN_DEF  = 13;
    localparam int VALUE_BITS_DEF  = 20;

    localparam int CFG_BITS       = 9;
    localparam int ENTRY_IDX_BITS = 8;
    localparam int ELEM_IDX_BITS  = 4;
    localparam int LABEL_BITS     = 8;
    localparam int DIST_BITS      = 44;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_INIT  = 3'd1,
        ST_ISSUE = 3'd2,
        ST_DRAIN = 3'd3,
        ST_PUT   = 3'd4
    } step_t;

    typedef enum logic [2:0] {
        COND_ALWAYS     = 3'd0,
        COND_START      = 3'd1,
        COND_EMPTY      = 3'd2,
        COND_SCAN_DONE  = 3'd3,
        COND_PIPE_EMPTY = 3'd4,
        COND_OUT_FREE   = 3'd5
    } cond_t;

    typedef struct packed {
        cond_t cond;
        step_t tgt_true;
        step_t tgt_false;
        logic  accept;
        logic  init;
        logic  issue;
        logic  load_out;
    } ucode_t;

    typedef struct packed {
        logic accept;
        logic init;
        logic issue;
        logic load_out;
    } seq_ctrl_t;

    typedef struct packed {
        logic start;
        logic empty;
        logic scan_done;
        logic pipe_empty;
        logic out_free;
    } seq_stat_t;

    // control store
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        w = '{cond: COND_ALWAYS, tgt_true: ST_IDLE, tgt_false: ST_IDLE,
              accept: 1'b0, init: 1'b0, issue: 1'b0, load_out: 1'b0};
        unique case (step)
            ST_IDLE: begin
                w.cond      = COND_START;
                w.tgt_true  = ST_INIT;
                w.tgt_false = ST_IDLE;
                w.accept    = 1'b1;
            end
            ST_INIT: begin
                w.cond      = COND_EMPTY;
                w.tgt_true  = ST_PUT;
                w.tgt_false = ST_ISSUE;
                w.init      = 1'b1;
            end
            ST_ISSUE: begin
                w.cond      = COND_SCAN_DONE;
                w.tgt_true  = ST_DRAIN;
                w.tgt_false = ST_ISSUE;
                w.issue     = 1'b1;
            end
            ST_DRAIN: begin
                w.cond      = COND_PIPE_EMPTY;
                w.tgt_true  = ST_PUT;
                w.tgt_false = ST_DRAIN;
            end
            ST_PUT: begin
                w.cond      = COND_OUT_FREE;
                w.tgt_true  = ST_IDLE;
                w.tgt_false = ST_PUT;
                w.load_out  = 1'b1;
            end
            default: begin
                w.cond      = COND_ALWAYS;
                w.tgt_true  = ST_IDLE;
                w.tgt_false = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> sv/nccls_seq.sv
// nccls_seq: microcode sequencer, step register plus control store lookup
// depends on nccls_pkg
`default_nettype none

module nccls_seq
    import nccls_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire seq_stat_t stat,
    output seq_ctrl_t      ctrl
);

    step_t  step_reg;
    step_t  step_next;
    ucode_t uw;
    logic   cond_ok;

    always_comb begin
        uw = ucode_rom(step_reg);
    end

    always_comb begin
        unique case (uw.cond)
            COND_ALWAYS:     cond_ok = 1'b1;
            COND_START:      cond_ok = stat.start;
            COND_EMPTY:      cond_ok = stat.empty;
            COND_SCAN_DONE:  cond_ok = stat.scan_done;
            COND_PIPE_EMPTY: cond_ok = stat.pipe_empty;
            COND_OUT_FREE:   cond_ok = stat.out_free;
            default:         cond_ok = 1'b0;
        endcase
    end

    // next step
    always_comb begin
        step_next = cond_ok ? uw.tgt_true : uw.tgt_false;
    end

    // control word outputs
    always_comb begin
        ctrl.accept   = uw.accept;
        ctrl.init     = uw.init;
        ctrl.issue    = uw.issue;
        ctrl.load_out = uw.load_out & cond_ok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ST_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/nearest_codeword_classifier.sv
// nearest_codeword_classifier: codebook memory, query memory and the
// distance pipeline, driven by the microcode sequencer
// depends on nccls_pkg and nccls_seq
//
// Usage: the s_ channel carries codebook writes (opcode 0) and query
// elements (opcode 1). Writes and query elements without last are taken
// one per cycle while idle and give no output. A query element with last set
// starts a search of the first active_entries codewords (cfg_wr_en /
// cfg_wr_data, written while idle). The m_ channel returns one result per
// search: nearest label, squared distance and a found flag; ties go to the
// later label, an empty codebook gives found low and zero fields.
// A search is paced by the single multiply-accumulate unit, which reads one
// codebook element per cycle; s_ready is low from the start of a search until
// its result has been loaded. The result sits in an output
// register, so new writes and query elements are taken while m_valid waits;
// a search that finishes while the result register is still full holds
// until m_ready. Reset clears active_entries and the control state; the
// codebook and query memories keep no reset value and must be written
// before use.
`default_nettype none

module nearest_codeword_classifier
    import nccls_pkg::*;
#(
    parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
    parameter int VECTOR_LEN  = VECTOR_LEN_DEF,
    parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [CFG_BITS-1:0]          cfg_wr_data,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_opcode,
    input  wire logic [ENTRY_IDX_BITS-1:0]    s_entry_index,
    input  wire logic [ELEM_IDX_BITS-1:0]     s_element_index,
    input  wire logic signed [VALUE_BITS-1:0] s_element_value,
    input  wire logic                         s_last,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [LABEL_BITS-1:0]             m_best_label,
    output logic [DIST_BITS-1:0]              m_best_distance,
    output logic                              m_found
);

    localparam int EN_W     = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int EW       = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;
    localparam int CNT_W    = $clog2(NUM_ENTRIES + 1);
    localparam int CMP_W    = (CNT_W > CFG_BITS) ? CNT_W : CFG_BITS;
    localparam int CB_DEPTH = NUM_ENTRIES * (1 << EW);
    localparam int SQ_W     = 2 * VALUE_BITS;
    localparam int ACC_FULL = SQ_W + ((VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 0);
    localparam int ACC_W    = (ACC_FULL > 64) ? 64 : ACC_FULL;

    seq_ctrl_t ctrl;
    seq_stat_t stat;

    logic [CFG_BITS-1:0] active_reg;
    logic [CNT_W-1:0]    cnt;

    logic in_acc;
    logic cb_we;
    logic q_we;
    logic [EN_W+EW-1:0] cb_waddr;
    logic [EN_W+EW-1:0] cb_raddr;

    logic [VALUE_BITS-1:0] cb_mem [0:CB_DEPTH-1];
    logic [VALUE_BITS-1:0] q_mem  [0:VECTOR_LEN-1];

    logic [CNT_W-1:0] ent_reg;
    logic [EW-1:0]    k_reg;
    logic             k_last;

    // stage 1: memory read data
    logic [VALUE_BITS-1:0] cb_rd_reg;
    logic [VALUE_BITS-1:0] q_rd_reg;
    logic                  v1_reg;
    logic                  last1_reg;
    logic [EN_W-1:0]       lab1_reg;
    // stage 2: absolute difference
    logic signed [VALUE_BITS:0] diff;
    logic [VALUE_BITS-1:0]      absd_next;
    logic [VALUE_BITS-1:0]      absd_reg;
    logic                       v2_reg;
    logic                       last2_reg;
    logic [EN_W-1:0]            lab2_reg;
    // stage 3: square
    logic [SQ_W-1:0] sq_next;
    logic [SQ_W-1:0] sq_reg;
    logic            v3_reg;
    logic            last3_reg;
    logic [EN_W-1:0] lab3_reg;
    // accumulate and compare
    logic [ACC_W-1:0] sum;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] best_dist_reg;
    logic [EN_W-1:0]  best_lab_reg;
    logic             have_reg;
    logic             take_best;

    logic                  m_valid_reg;
    logic [LABEL_BITS-1:0] m_label_reg;
    logic [DIST_BITS-1:0]  m_dist_reg;
    logic                  m_found_reg;

    nccls_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= '0;
        end else if (cfg_wr_en) begin
            active_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        if (CMP_W'(active_reg) > CMP_W'(NUM_ENTRIES)) begin
            cnt = CNT_W'(NUM_ENTRIES);
        end else begin
            cnt = CNT_W'(active_reg);
        end
    end

    // input side
    assign s_ready  = ctrl.accept;
    assign in_acc   = s_valid & s_ready;
    assign cb_we    = in_acc & ~s_opcode
                    & (32'(s_entry_index) < 32'(NUM_ENTRIES))
                    & (32'(s_element_index) < 32'(VECTOR_LEN));
    assign q_we     = in_acc & s_opcode & (32'(s_element_index) < 32'(VECTOR_LEN));
    assign cb_waddr = {EN_W'(s_entry_index), EW'(s_element_index)};
    assign cb_raddr = {ent_reg[EN_W-1:0], k_reg};

    always_ff @(posedge aclk) begin
        if (cb_we) begin
            cb_mem[cb_waddr] <= s_element_value;
        end
        if (ctrl.issue) begin
            cb_rd_reg <= cb_mem[cb_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (q_we) begin
            q_mem[EW'(s_element_index)] <= s_element_value;
        end
        if (ctrl.issue) begin
            q_rd_reg <= q_mem[k_reg];
        end
    end

    // scan counters
    assign k_last = (k_reg == EW'(VECTOR_LEN - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_reg <= '0;
            k_reg   <= '0;
        end else if (ctrl.init) begin
            ent_reg <= '0;
            k_reg   <= '0;
        end else if (ctrl.issue) begin
            if (k_last) begin
                k_reg   <= '0;
                ent_reg <= ent_reg + CNT_W'(1);
            end else begin
                k_reg <= k_reg + EW'(1);
            end
        end
    end

    // datapath
    assign diff = $signed({q_rd_reg[VALUE_BITS-1], q_rd_reg})
                - $signed({cb_rd_reg[VALUE_BITS-1], cb_rd_reg});
    assign absd_next = diff[VALUE_BITS] ? VALUE_BITS'(-diff) : VALUE_BITS'(diff);
    assign sq_next   = SQ_W'(absd_reg) * SQ_W'(absd_reg);
    assign sum       = acc_reg + ACC_W'(sq_reg);
    assign take_best = v3_reg & last3_reg & (~have_reg | (sum <= best_dist_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= ctrl.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        last1_reg <= k_last;
        lab1_reg  <= ent_reg[EN_W-1:0];
        absd_reg  <= absd_next;
        last2_reg <= last1_reg;
        lab2_reg  <= lab1_reg;
        sq_reg    <= sq_next;
        last3_reg <= last2_reg;
        lab3_reg  <= lab2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            have_reg <= 1'b0;
        end else if (ctrl.init) begin
            acc_reg  <= '0;
            have_reg <= 1'b0;
        end else if (v3_reg) begin
            acc_reg <= last3_reg ? '0 : sum;
            if (take_best) begin
                have_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_best) begin
            best_dist_reg <= sum;
            best_lab_reg  <= lab3_reg;
        end
    end

    // sequencer status
    always_comb begin
        stat.start      = in_acc & s_opcode & s_last;
        stat.empty      = (cnt == '0);
        stat.scan_done  = k_last & ((ent_reg + CNT_W'(1)) == cnt);
        stat.pipe_empty = ~(v1_reg | v2_reg | v3_reg);
        stat.out_free   = ~m_valid_reg | m_ready;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_out) begin
            m_found_reg <= have_reg;
            m_label_reg <= have_reg ? LABEL_BITS'(best_lab_reg) : '0;
            m_dist_reg  <= have_reg ? DIST_BITS'(best_dist_reg) : '0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_found         = m_found_reg;
    assign m_best_label    = m_label_reg;
    assign m_best_distance = m_dist_reg;

`ifndef NO_ASSERTIONS
    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg || v2_reg || v3_reg) |-> !s_ready)
        else $error("input taken while search in flight");

    a_load_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.load_out |-> !(v1_reg || v2_reg || v3_reg))
        else $error("result loaded before pipeline drained");

    a_elem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.issue |-> (32'(k_reg) < 32'(VECTOR_LEN)) && (ent_reg < cnt))
        else $error("scan address out of range");

    a_out_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> !ctrl.load_out || $past(ctrl.load_out) == 1'b0)
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
